// ===== design/xmcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// xmcrc_pkg
// Types, codes and the CRC-16 byte update shared by the XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package xmcrc_pkg;

  // Payload bytes in one block
  localparam int unsigned BLOCK_BYTES = 128;

  // Protocol characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  ERROR_LIMIT_RESET = 8'd10;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_START   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  // Transfer status
  typedef enum logic [1:0] {
    FIN_RUNNING  = 2'd0,
    FIN_COMPLETE = 2'd1,
    FIN_ABORTED  = 2'd2
  } finished_t;

  // Receiver phase
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_HDR   = 4'd1,
    PH_AFTER = 4'd2,
    PH_SEQ   = 4'd3,
    PH_COMP  = 4'd4,
    PH_DATA  = 4'd5,
    PH_CRCHI = 4'd6,
    PH_CRCLO = 4'd7,
    PH_DRAIN = 4'd8,
    PH_DONE  = 4'd9,
    PH_ABORT = 4'd10
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       block_commit;
    logic       block_discard;
    logic [1:0] finished;
  } out_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/xmodem_crc_block_receiver_core.sv =====
// ----------------------------------------------------------------------------
// xmodem_crc_block_receiver_core
// XMODEM-CRC receiver: header and sequence checks, streamed CRC-16 payload,
// commit or discard per block, reply bytes and error budget.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                       | Beat
//  --------+-------------------------------+-----------------------------------
//  in      | in_valid, in_ready, in_data   | one opcode and received byte
//  out     | out_valid, out_ready, out_data| one result for every input beat
//  cfg     | cfg_valid, cfg_ready, cfg_data| error_limit write, always ready
//
//  Each input beat is decoded into the result register; one beat per cycle is
//  sustained while out is ready. The single result register sets the figure:
//  in_ready is high while it is empty or being drained in the same cycle, so a
//  stall on out holds the input side only once the register is full. Reset
//  (rst, synchronous) puts the receiver in idle with error_limit at 10.
//
module xmodem_crc_block_receiver_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  xmcrc_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output xmcrc_pkg::out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data
);
  import xmcrc_pkg::*;

  logic [7:0]  error_limit;
  phase_t      phase, phase_next;
  logic [7:0]  last_good_seq, last_good_seq_next;
  logic [7:0]  header_seq, header_seq_next;
  logic [6:0]  byte_index, byte_index_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [7:0]  crc_high, crc_high_next;
  logic [9:0]  error_count, error_count_next;
  logic [7:0]  error_budget, error_budget_next;
  logic [7:0]  pending_reply, pending_reply_next;
  logic        block_bad, block_bad_next;
  out_t        result;

  logic        take;
  opcode_t     op;
  logic [7:0]  b;
  logic        comp_ok, seq_is_next, seq_is_dup, crc_ok, last_byte;
  logic [8:0]  comp_sum;

  assign in_ready  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign op        = opcode_t'(in_data.opcode);
  assign b         = in_data.rx_byte;

  // Decode header and CRC checks
  assign comp_sum    = {1'b0, header_seq} + {1'b0, b};
  assign comp_ok     = (comp_sum == 9'd255);
  assign seq_is_next = (header_seq == last_good_seq + 8'd1);
  assign seq_is_dup  = (header_seq == last_good_seq);
  assign crc_ok      = !block_bad && ({crc_high, b} == crc_acc);
  assign last_byte   = (byte_index == 7'(BLOCK_BYTES - 1));

  // Next state
  always_comb begin
    logic [9:0] cnt;
    cnt                = error_count;
    phase_next         = phase;
    last_good_seq_next = last_good_seq;
    header_seq_next    = header_seq;
    byte_index_next    = byte_index;
    crc_acc_next       = crc_acc;
    crc_high_next      = crc_high;
    error_count_next   = error_count;
    error_budget_next  = error_budget;
    pending_reply_next = pending_reply;
    block_bad_next     = block_bad;
    unique case (op)
      OP_START: begin
        last_good_seq_next = '0;
        header_seq_next    = '0;
        byte_index_next    = '0;
        crc_acc_next       = '0;
        crc_high_next      = '0;
        error_count_next   = '0;
        error_budget_next  = error_limit;
        pending_reply_next = CH_C;
        block_bad_next     = 1'b0;
        phase_next         = PH_HDR;
      end
      OP_BYTE: begin
        unique case (phase)
          PH_HDR, PH_AFTER: begin
            phase_next = PH_HDR;
            if (b == CH_SOH) begin
              phase_next = PH_SEQ;
            end else if (b == CH_EOT) begin
              phase_next = (error_count < {2'b00, error_budget}) ? PH_DONE : PH_ABORT;
            end
          end
          PH_SEQ: begin
            header_seq_next = b;
            phase_next      = PH_COMP;
          end
          PH_COMP: begin
            if (!comp_ok) begin
              cnt                = error_count + 10'd1;
              error_count_next   = cnt;
              pending_reply_next = CH_NAK;
              phase_next         = (cnt > {2'b00, error_budget}) ? PH_ABORT : PH_AFTER;
            end else if (seq_is_next) begin
              crc_acc_next    = '0;
              byte_index_next = '0;
              block_bad_next  = 1'b0;
              phase_next      = PH_DATA;
            end else if (seq_is_dup) begin
              phase_next = PH_DRAIN;
            end else begin
              // Sequence jump: charge the whole limit, then the error itself
              cnt                = error_count + {2'b00, error_limit} + 10'd1;
              error_count_next   = cnt;
              pending_reply_next = CH_NAK;
              phase_next         = (cnt > {2'b00, error_budget}) ? PH_ABORT : PH_AFTER;
            end
          end
          PH_DATA: begin
            crc_acc_next = crc_update(crc_acc, b);
            if (last_byte) begin
              byte_index_next = '0;
              phase_next      = PH_CRCHI;
            end else begin
              byte_index_next = byte_index + 7'd1;
            end
          end
          PH_CRCHI: begin
            crc_high_next = b;
            phase_next    = PH_CRCLO;
          end
          PH_CRCLO: begin
            block_bad_next = 1'b0;
            if (crc_ok) begin
              last_good_seq_next = last_good_seq + 8'd1;
              error_count_next   = '0;
              error_budget_next  = error_limit;
              phase_next         = PH_AFTER;
            end else begin
              cnt                = error_count + 10'd1;
              error_count_next   = cnt;
              pending_reply_next = CH_NAK;
              phase_next         = (cnt > {2'b00, error_budget}) ? PH_ABORT : PH_AFTER;
            end
          end
          default: begin
          end
        endcase
      end
      OP_TIMEOUT: begin
        unique case (phase)
          PH_HDR, PH_SEQ, PH_COMP, PH_DRAIN: begin
            cnt                = error_count + 10'd1;
            error_count_next   = cnt;
            pending_reply_next = CH_NAK;
            phase_next         = (cnt > {2'b00, error_budget}) ? PH_ABORT : PH_AFTER;
          end
          PH_AFTER: begin
            cnt              = error_count + 10'd1;
            error_count_next = cnt;
            phase_next       = (cnt > {2'b00, error_budget}) ? PH_ABORT : PH_HDR;
          end
          PH_DATA: begin
            block_bad_next = 1'b1;
          end
          PH_CRCHI, PH_CRCLO: begin
            // Discard counts once, then the normal error path counts again
            block_bad_next     = 1'b0;
            cnt                = error_count + 10'd2;
            error_count_next   = cnt;
            pending_reply_next = CH_NAK;
            phase_next         = (cnt > {2'b00, error_budget}) ? PH_ABORT : PH_AFTER;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Result fields
  always_comb begin
    result = '0;
    unique case (op)
      OP_START: begin
        result.reply_valid   = 1'b1;
        result.reply_byte    = CH_C;
        result.block_discard = (phase == PH_DATA) || (phase == PH_CRCHI) ||
                               (phase == PH_CRCLO);
      end
      OP_BYTE: begin
        unique case (phase)
          PH_HDR, PH_AFTER: begin
            if (b == CH_EOT && error_count < {2'b00, error_budget}) begin
              result.reply_valid = 1'b1;
              result.reply_byte  = CH_ACK;
            end
          end
          PH_COMP: begin
            if (!comp_ok) begin
              result.reply_valid = 1'b1;
              result.reply_byte  = pending_reply;
            end else if (!seq_is_next && !seq_is_dup) begin
              result.reply_valid = 1'b1;
              result.reply_byte  = CH_EOT;
            end
          end
          PH_DATA: begin
            result.data_valid = 1'b1;
            result.data_byte  = b;
          end
          PH_CRCLO: begin
            result.reply_valid = 1'b1;
            if (crc_ok) begin
              result.block_commit = 1'b1;
              result.reply_byte   = CH_ACK;
            end else begin
              result.block_discard = 1'b1;
              result.reply_byte    = pending_reply;
            end
          end
          default: begin
          end
        endcase
      end
      OP_TIMEOUT: begin
        unique case (phase)
          PH_HDR, PH_SEQ, PH_COMP: begin
            result.reply_valid = 1'b1;
            result.reply_byte  = pending_reply;
          end
          PH_CRCHI, PH_CRCLO: begin
            result.reply_valid   = 1'b1;
            result.reply_byte    = pending_reply;
            result.block_discard = 1'b1;
          end
          PH_DRAIN: begin
            result.reply_valid = 1'b1;
            result.reply_byte  = CH_ACK;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    if (phase_next == PH_DONE) begin
      result.finished = FIN_COMPLETE;
    end else if (phase_next == PH_ABORT) begin
      result.finished = FIN_ABORTED;
    end else begin
      result.finished = FIN_RUNNING;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit <= ERROR_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      error_limit <= cfg_data;
    end
  end

  // Advance receiver state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      last_good_seq <= '0;
      header_seq    <= '0;
      byte_index    <= '0;
      crc_acc       <= '0;
      crc_high      <= '0;
      error_count   <= '0;
      error_budget  <= ERROR_LIMIT_RESET;
      pending_reply <= CH_C;
      block_bad     <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      last_good_seq <= last_good_seq_next;
      header_seq    <= header_seq_next;
      byte_index    <= byte_index_next;
      crc_acc       <= crc_acc_next;
      crc_high      <= crc_high_next;
      error_count   <= error_count_next;
      error_budget  <= error_budget_next;
      pending_reply <= pending_reply_next;
      block_bad     <= block_bad_next;
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result;
    end
  end

endmodule

// ===== dv/xmodem_crc_block_receiver_checker.sv =====
// ----------------------------------------------------------------------------
// xmodem_crc_block_receiver_checker
// Watches the in, out and cfg channels of the XMODEM-CRC receiver, keeps its
// own model of the receiver state, and compares every result beat against
// the outcome predicted for the oldest input beat still outstanding.
// ----------------------------------------------------------------------------
module xmodem_crc_block_receiver_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  xmcrc_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  xmcrc_pkg::out_t out_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [7:0]      cfg_data,
  output int              mismatches,
  output int              outstanding,
  output int              results_checked,
  output int              blocks_committed,
  output int              blocks_discarded,
  output int              transfers_done,
  output int              transfers_aborted
);
  timeunit 1ns;
  timeprecision 1ps;
  import xmcrc_pkg::*;

  // Receiver model state
  phase_t      rx_phase;
  logic [7:0]  limit_reg;
  logic [7:0]  good_seq;
  logic [7:0]  hdr_seq;
  logic [6:0]  data_idx;
  logic [15:0] crc_run;
  logic [7:0]  crc_hi;
  logic [9:0]  err_cnt;
  logic [9:0]  err_budget;
  logic [7:0]  next_reply;
  logic        data_bad;

  // Outcomes predicted for accepted input beats, oldest first
  out_t predicted_outcomes[$];

  // CRC-16 (0x1021), fed one message bit at a time, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  task automatic clear_model();
    rx_phase   = PH_IDLE;
    limit_reg  = ERROR_LIMIT_RESET;
    good_seq   = '0;
    hdr_seq    = '0;
    data_idx   = '0;
    crc_run    = '0;
    crc_hi     = '0;
    err_cnt    = '0;
    err_budget = 10'(ERROR_LIMIT_RESET);
    next_reply = CH_C;
    data_bad   = 1'b0;
  endtask

  // Add errors and abort once the count passes the budget
  task automatic log_error(input logic [9:0] n);
    err_cnt = err_cnt + n;
  endtask

  task automatic budget_check();
    if (err_cnt > err_budget) begin
      rx_phase = PH_ABORT;
    end
  endtask

  // Common error handling: one error, send the pending reply, then NAK
  task automatic fault_reply(inout out_t r);
    log_error(10'd1);
    r.reply_valid = 1'b1;
    r.reply_byte  = next_reply;
    next_reply    = CH_NAK;
    rx_phase      = PH_AFTER;
    budget_check();
  endtask

  task automatic predict_beat(input in_t beat, output out_t r);
    phase_t     was;
    logic [7:0] b;
    r   = '0;
    was = rx_phase;
    b   = beat.rx_byte;
    case (opcode_t'(beat.opcode))
      OP_START: begin
        if (rx_phase == PH_DATA || rx_phase == PH_CRCHI || rx_phase == PH_CRCLO) begin
          r.block_discard = 1'b1;
        end
        good_seq      = '0;
        hdr_seq       = '0;
        data_idx      = '0;
        crc_run       = '0;
        crc_hi        = '0;
        err_cnt       = '0;
        err_budget    = 10'(limit_reg);
        next_reply    = CH_C;
        data_bad      = 1'b0;
        r.reply_valid = 1'b1;
        r.reply_byte  = CH_C;
        rx_phase      = PH_HDR;
      end
      OP_BYTE: begin
        case (rx_phase)
          PH_HDR, PH_AFTER: begin
            // Any byte after a reply is a header candidate
            rx_phase = PH_HDR;
            if (b == CH_SOH) begin
              rx_phase = PH_SEQ;
            end else if (b == CH_EOT) begin
              if (err_cnt < err_budget) begin
                r.reply_valid = 1'b1;
                r.reply_byte  = CH_ACK;
                rx_phase      = PH_DONE;
              end else begin
                rx_phase = PH_ABORT;
              end
            end
          end
          PH_SEQ: begin
            hdr_seq  = b;
            rx_phase = PH_COMP;
          end
          PH_COMP: begin
            if ((9'(hdr_seq) + 9'(b)) != 9'd255) begin
              fault_reply(r);
            end else if (hdr_seq == good_seq + 8'd1) begin
              crc_run  = '0;
              data_idx = '0;
              data_bad = 1'b0;
              rx_phase = PH_DATA;
            end else if (hdr_seq == good_seq) begin
              rx_phase = PH_DRAIN;
            end else begin
              // Sequence jump: reply EOT and push the count past the budget
              next_reply = CH_EOT;
              log_error(10'(limit_reg));
              fault_reply(r);
            end
          end
          PH_DATA: begin
            r.data_valid = 1'b1;
            r.data_byte  = b;
            crc_run      = crc16_step(crc_run, b);
            if (data_idx >= 7'(BLOCK_BYTES - 1)) begin
              data_idx = '0;
              rx_phase = PH_CRCHI;
            end else begin
              data_idx = data_idx + 7'd1;
            end
          end
          PH_CRCHI: begin
            crc_hi   = b;
            rx_phase = PH_CRCLO;
          end
          PH_CRCLO: begin
            if (!data_bad && {crc_hi, b} == crc_run) begin
              r.block_commit = 1'b1;
              good_seq       = good_seq + 8'd1;
              err_cnt        = '0;
              err_budget     = 10'(limit_reg);
              r.reply_valid  = 1'b1;
              r.reply_byte   = CH_ACK;
              rx_phase       = PH_AFTER;
            end else begin
              r.block_discard = 1'b1;
              fault_reply(r);
            end
            data_bad = 1'b0;
          end
          default: begin
          end
        endcase
      end
      OP_TIMEOUT: begin
        case (rx_phase)
          PH_HDR, PH_SEQ, PH_COMP: begin
            fault_reply(r);
          end
          PH_AFTER: begin
            log_error(10'd1);
            rx_phase = PH_HDR;
            budget_check();
          end
          PH_DATA: begin
            data_bad = 1'b1;
          end
          PH_CRCHI, PH_CRCLO: begin
            r.block_discard = 1'b1;
            data_bad        = 1'b0;
            log_error(10'd1);
            fault_reply(r);
          end
          PH_DRAIN: begin
            next_reply = CH_ACK;
            fault_reply(r);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (rx_phase == PH_DONE) begin
      r.finished = FIN_COMPLETE;
    end else if (rx_phase == PH_ABORT) begin
      r.finished = FIN_ABORTED;
    end
    if (rx_phase == PH_DONE && was != PH_DONE) begin
      transfers_done++;
    end
    if (rx_phase == PH_ABORT && was != PH_ABORT) begin
      transfers_aborted++;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Track config writes, check result beats, predict input beats
  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      clear_model();
      predicted_outcomes.delete();
      mismatches        = 0;
      results_checked   = 0;
      blocks_committed  = 0;
      blocks_discarded  = 0;
      transfers_done    = 0;
      transfers_aborted = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (predicted_outcomes.size() == 0) begin
          $error("result beat 0x%0h arrived with no outcome outstanding", out_data);
          mismatches++;
        end else begin
          want = predicted_outcomes.pop_front();
          check_field("reply_valid", 8'(want.reply_valid), 8'(out_data.reply_valid));
          check_field("reply_byte", want.reply_byte, out_data.reply_byte);
          check_field("data_valid", 8'(want.data_valid), 8'(out_data.data_valid));
          check_field("data_byte", want.data_byte, out_data.data_byte);
          check_field("block_commit", 8'(want.block_commit), 8'(out_data.block_commit));
          check_field("block_discard", 8'(want.block_discard), 8'(out_data.block_discard));
          check_field("finished", 8'(want.finished), 8'(out_data.finished));
          results_checked++;
          if (want.block_commit) begin
            blocks_committed++;
          end
          if (want.block_discard) begin
            blocks_discarded++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_beat(in_data, want);
        predicted_outcomes.push_back(want);
      end
    end
    outstanding = predicted_outcomes.size();
  end

endmodule

// ===== dv/xmodem_crc_block_receiver_core_tb.sv =====
// ----------------------------------------------------------------------------
// xmodem_crc_block_receiver_core_tb
// Drives the XMODEM-CRC receiver with a short directed opening and then
// random transfers (good, corrupted, timed-out, duplicate and jumped blocks,
// restarts and line noise) under varying back-pressure and error limits.
// A checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module xmodem_crc_block_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xmcrc_pkg::*;

  localparam int RANDOM_BEATS = 1850;
  localparam int LIMIT_CYCLES = 400000;
  localparam int STALL_AT     = 1400;
  localparam int STALL_CYCLES = 400;

  typedef enum int {
    BLK_GOOD,
    BLK_BAD_CRC,
    BLK_BAD_COMP,
    BLK_DATA_TIMEOUT,
    BLK_CRC_TIMEOUT,
    BLK_DUP,
    BLK_CUT,
    BLK_JUMP
  } blk_kind_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  int mismatches;
  int outstanding;
  int results_checked;
  int blocks_committed;
  int blocks_discarded;
  int transfers_done;
  int transfers_aborted;

  int items_sent   = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int limit_writes = 0;
  int stall_left   = 0;
  bit stall_done   = 1'b0;
  int cycles       = 0;

  xmodem_crc_block_receiver_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  xmodem_crc_block_receiver_checker chk (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .results_checked   (results_checked),
    .blocks_committed  (blocks_committed),
    .blocks_discarded  (blocks_discarded),
    .transfers_done    (transfers_done),
    .transfers_aborted (transfers_aborted)
  );

  always #10 clk = ~clk;

  // Result side: random stalls, plus one long hold-off to fill the block
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && items_sent >= STALL_AT) begin
      out_ready  <= 1'b0;
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Sender-side CRC used to frame blocks
  function automatic logic [15:0] frame_crc(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Offer one input beat, with an optional idle gap ahead of it
  task automatic send_beat(input opcode_t op, input logic [7:0] b);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= in_t'({op, b});
    do @(posedge clk); while (!in_ready);
    items_sent <= items_sent + 1;
  endtask

  // Drop valid and wait until every outstanding result has drained
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(3))
      0:       return 8'd1;
      1:       return 8'd255;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic blk_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 55) return BLK_GOOD;
    if (r < 63) return BLK_BAD_CRC;
    if (r < 70) return BLK_BAD_COMP;
    if (r < 77) return BLK_DATA_TIMEOUT;
    if (r < 84) return BLK_CRC_TIMEOUT;
    if (r < 91) return BLK_DUP;
    if (r < 95) return BLK_CUT;
    return BLK_JUMP;
  endfunction

  // Stray timeouts, junk bytes and unused opcodes between blocks
  task automatic line_noise();
    int n;
    n = ($urandom_range(9) < 3) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      case ($urandom_range(3))
        0:       send_beat(OP_TIMEOUT, 8'($urandom));
        1:       send_beat(OP_NONE, 8'($urandom));
        default: send_beat(OP_BYTE, 8'($urandom));
      endcase
    end
  endtask

  // Send one block of the given kind; cut is set when it stops mid-payload
  task automatic send_block(inout logic [7:0] seq, input blk_kind_t kind, output bit cut);
    logic [7:0]  hdr;
    logic [7:0]  comp;
    logic [7:0]  b;
    logic [15:0] crc;
    int          n;
    int          tpos;
    cut = 1'b0;
    hdr = seq;
    if (kind == BLK_DUP) begin
      hdr = seq - 8'd1;
    end else if (kind == BLK_JUMP) begin
      hdr = seq + 8'($urandom_range(1, 253));
    end
    comp = ~hdr;
    if (kind == BLK_BAD_COMP) begin
      comp = comp ^ 8'($urandom_range(1, 255));
    end
    send_beat(OP_BYTE, CH_SOH);
    send_beat(OP_BYTE, hdr);
    send_beat(OP_BYTE, comp);
    if (kind == BLK_BAD_COMP || kind == BLK_JUMP) begin
      return;
    end
    if (kind == BLK_DUP) begin
      // Drain a few bytes of the repeated block, then let the timeout fire
      repeat ($urandom_range(0, 6)) send_beat(OP_BYTE, 8'($urandom));
      send_beat(OP_TIMEOUT, 8'($urandom));
      return;
    end
    crc  = '0;
    n    = (kind == BLK_CUT) ? $urandom_range(0, BLOCK_BYTES - 1) : BLOCK_BYTES;
    tpos = $urandom_range(0, BLOCK_BYTES - 1);
    for (int i = 0; i < n; i++) begin
      if (kind == BLK_DATA_TIMEOUT && i == tpos) begin
        send_beat(OP_TIMEOUT, 8'($urandom));
      end
      b   = 8'($urandom);
      crc = frame_crc(crc, b);
      send_beat(OP_BYTE, b);
    end
    if (kind == BLK_CUT) begin
      cut = 1'b1;
      return;
    end
    if (kind == BLK_CRC_TIMEOUT) begin
      if ($urandom_range(1)) begin
        send_beat(OP_BYTE, crc[15:8]);
      end
      send_beat(OP_TIMEOUT, 8'($urandom));
      return;
    end
    if (kind == BLK_BAD_CRC) begin
      crc = crc ^ 16'($urandom_range(1, 65535));
    end
    send_beat(OP_BYTE, crc[15:8]);
    send_beat(OP_BYTE, crc[7:0]);
    if (kind == BLK_GOOD) begin
      seq = seq + 8'd1;
    end
  endtask

  // One transfer: new limit while idle, start, a few blocks, usually EOT
  task automatic run_session();
    logic [7:0] seq;
    int         nblk;
    bit         cut;
    seq  = 8'd1;
    cut  = 1'b0;
    nblk = $urandom_range(0, 3);
    settle();
    write_limit(pick_limit());
    if ($urandom_range(9) == 0) begin
      send_beat(OP_BYTE, 8'($urandom));
    end
    send_beat(OP_START, 8'($urandom));
    for (int k = 0; k < nblk && !cut; k++) begin
      line_noise();
      send_block(seq, pick_kind(), cut);
    end
    if (!cut && $urandom_range(4) != 0) begin
      send_beat(OP_BYTE, CH_EOT);
    end
  endtask

  // Watchdog
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int base;
    int seg_end;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 9;
    rx_idle_pct <= 66;
    write_limit(ERROR_LIMIT_RESET);

    // Directed opening: ignored beats, header errors, duplicate, EOT,
    // restart inside a block and a sequence jump
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_TIMEOUT, 8'h00);
    send_beat(OP_NONE, 8'hAA);
    send_beat(OP_START, 8'h00);
    send_beat(OP_TIMEOUT, 8'h00);
    send_beat(OP_TIMEOUT, 8'h00);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, CH_SOH);
    send_beat(OP_TIMEOUT, 8'h00);
    send_beat(OP_BYTE, CH_SOH);
    send_beat(OP_BYTE, 8'h01);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, CH_SOH);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_TIMEOUT, 8'h00);
    send_beat(OP_BYTE, CH_EOT);
    send_beat(OP_START, 8'hFF);
    send_beat(OP_BYTE, CH_SOH);
    send_beat(OP_BYTE, 8'h01);
    send_beat(OP_BYTE, 8'hFE);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_TIMEOUT, 8'h00);
    send_beat(OP_START, 8'h00);
    send_beat(OP_BYTE, CH_SOH);
    send_beat(OP_BYTE, 8'h07);
    send_beat(OP_BYTE, 8'hF8);
    send_beat(OP_BYTE, CH_EOT);
    settle();

    // Random transfers under three idling profiles
    base = items_sent;
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          tx_idle_pct = 9;
          rx_idle_pct <= 66;
        end
        1: begin
          tx_idle_pct = 66;
          rx_idle_pct <= 9;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      seg_end = base + (seg + 1) * RANDOM_BEATS / 3;
      while (items_sent < seg_end) begin
        run_session();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Checked %0d result beats from %0d input beats across %0d error_limit settings.",
             results_checked, items_sent, limit_writes);
    $display("Blocks committed %0d, discarded %0d; transfers completed %0d, aborted %0d.",
             blocks_committed, blocks_discarded, transfers_done, transfers_aborted);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
